/* hdl/skit_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package skit_pkg;

  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam int          MIN_BKT_LOG = 4;

  localparam logic [1:0] CMD_NAME   = 2'd0;
  localparam logic [1:0] CMD_FILE   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam int CAP_W   = 9;
  localparam int ID_W    = 8;
  localparam int HITS_W  = 32;
  localparam int LINE_W  = 32;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;

  typedef struct packed {
    logic key_name;
    logic key_file;
    logic fin_latch;
    logic clr_table;
    logic clr_step;
    logic idx_clr;
    logic idx_inc;
    logic rd_file;
    logic hash_file;
    logic hash_line;
    logic probe_start;
    logic rd_bkt;
    logic rd_ent;
    logic probe_next;
    logic rd_cmp_name;
    logic rd_cmp_file;
    logic rd_name;
    logic cp_wr;
    logic cp_src_file;
    logic set_noff;
    logic set_foff;
    logic commit;
    logic hit;
    logic resp;
    logic resp_found;
    logic resp_new;
  } cmd_t;

  typedef struct packed {
    logic name_empty;
    logic file_empty;
    logic name_last;
    logic file_last;
    logic line_last;
    logic bkt_empty;
    logic hdr_eq;
    logic name_eq;
    logic file_eq;
    logic probe_last;
    logic table_full;
    logic name_no_fit;
    logic file_no_fit;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/string_key_intern_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Interns (name, file, line) keys into dense frame ids.
// in_*: one word per cycle while in_tready is high. tuser selects the
//   word kind: name byte, file byte, finish with line, or clear. Name
//   bytes hash on arrival; file bytes are buffered and hashed at finish.
// A finish word hashes the buffered file bytes, then the four line bytes,
//   then probes buckets: each occupied bucket's entry header is compared,
//   then the name and file bytes one by one; an empty bucket ends the
//   probe and starts an insert, which copies the strings into the arena
//   byte by byte. The finish gives one out_* word.
// out_*: tuser is found, tdata holds frame id and the refused-insert count.
//   A waiting result sits in an output register; key bytes are still taken
//   meanwhile, and the next finish's result waits until that word is taken.
// cfg_*: writes capacity; always ready, and starts a table clear.
// Reset, a clear word and a cfg write each run a clear pass over all BUCKETS
//   buckets (512 by default), during which in_tready is low.
module string_key_intern_table_top #(
  parameter int FRAMES      = 256,
  parameter int BUCKETS     = 512,
  parameter int KEY_MAX     = 256,
  parameter int ARENA_BYTES = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // data_byte[7:0], line[39:8]
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // frame_id[7:0], refused_cnt[39:8]
  output logic             out_tuser,  // found
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);
  import skit_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  skit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .sts       (sts),
    .cmd       (cmd)
  );

  skit_dp #(
    .FRAMES      (FRAMES),
    .BUCKETS     (BUCKETS),
    .KEY_MAX     (KEY_MAX),
    .ARENA_BYTES (ARENA_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* hdl/skit_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module skit_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    in_tuser,
  input  wire logic          cfg_we,
  input  wire skit_pkg::sts_t sts,
  output skit_pkg::cmd_t     cmd
);
  import skit_pkg::*;

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_FH_RD   = 5'd2;
  localparam logic [4:0] S_FH_MUL  = 5'd3;
  localparam logic [4:0] S_LH      = 5'd4;
  localparam logic [4:0] S_PS      = 5'd5;
  localparam logic [4:0] S_PB_RD   = 5'd6;
  localparam logic [4:0] S_PB_CHK  = 5'd7;
  localparam logic [4:0] S_PE_CHK  = 5'd8;
  localparam logic [4:0] S_MISS    = 5'd9;
  localparam logic [4:0] S_CN_RD   = 5'd10;
  localparam logic [4:0] S_CN_CHK  = 5'd11;
  localparam logic [4:0] S_CF_RD   = 5'd12;
  localparam logic [4:0] S_CF_CHK  = 5'd13;
  localparam logic [4:0] S_INS     = 5'd14;
  localparam logic [4:0] S_CPN_RD  = 5'd15;
  localparam logic [4:0] S_CPN_WR  = 5'd16;
  localparam logic [4:0] S_FCHK    = 5'd17;
  localparam logic [4:0] S_CPF_RD  = 5'd18;
  localparam logic [4:0] S_CPF_WR  = 5'd19;
  localparam logic [4:0] S_COMMIT  = 5'd20;
  localparam logic [4:0] S_R_NONE  = 5'd21;
  localparam logic [4:0] S_R_FOUND = 5'd22;
  localparam logic [4:0] S_R_NEW   = 5'd23;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       in_acc;

  assign in_tready = (state_r == S_IDLE) && !cfg_we;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            CMD_NAME: cmd.key_name = 1'b1;
            CMD_FILE: cmd.key_file = 1'b1;
            CMD_CLEAR: begin
              cmd.clr_table = 1'b1;
              state_nxt     = S_CLR;
            end
            CMD_FINISH: begin
              cmd.fin_latch = 1'b1;
              if (sts.name_empty) state_nxt = S_R_NONE;
              else if (sts.file_empty) state_nxt = S_LH;
              else state_nxt = S_FH_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FH_RD: begin
        cmd.rd_file = 1'b1;
        state_nxt   = S_FH_MUL;
      end
      S_FH_MUL: begin
        cmd.hash_file = 1'b1;
        if (sts.file_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_LH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_FH_RD;
        end
      end
      S_LH: begin
        cmd.hash_line = 1'b1;
        if (sts.line_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_PS;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PS: begin
        cmd.probe_start = 1'b1;
        state_nxt       = S_PB_RD;
      end
      S_PB_RD: begin
        cmd.rd_bkt = 1'b1;
        state_nxt  = S_PB_CHK;
      end
      S_PB_CHK: begin
        if (sts.bkt_empty) begin
          state_nxt = S_INS;
        end else begin
          cmd.rd_ent = 1'b1;
          state_nxt  = S_PE_CHK;
        end
      end
      S_PE_CHK: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = sts.hdr_eq ? S_CN_RD : S_MISS;
      end
      S_MISS: begin
        if (sts.probe_last) begin
          cmd.hit   = 1'b1;
          state_nxt = S_R_NONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PB_RD;
        end
      end
      S_CN_RD: begin
        cmd.rd_cmp_name = 1'b1;
        state_nxt       = S_CN_CHK;
      end
      S_CN_CHK: begin
        priority if (!sts.name_eq) begin
          state_nxt = S_MISS;
        end else if (sts.name_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.file_empty ? S_R_FOUND : S_CF_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CN_RD;
        end
      end
      S_CF_RD: begin
        cmd.rd_cmp_file = 1'b1;
        state_nxt       = S_CF_CHK;
      end
      S_CF_CHK: begin
        priority if (!sts.file_eq) begin
          state_nxt = S_MISS;
        end else if (sts.file_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_R_FOUND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CF_RD;
        end
      end
      S_INS: begin
        priority if (sts.table_full || sts.name_no_fit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_R_NONE;
        end else begin
          cmd.set_noff = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_CPN_RD;
        end
      end
      S_CPN_RD: begin
        cmd.rd_name = 1'b1;
        state_nxt   = S_CPN_WR;
      end
      S_CPN_WR: begin
        cmd.cp_wr = 1'b1;
        if (sts.name_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_FCHK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CPN_RD;
        end
      end
      S_FCHK: begin
        priority if (sts.file_empty) begin
          state_nxt = S_COMMIT;
        end else if (sts.file_no_fit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_R_NONE;
        end else begin
          cmd.set_foff = 1'b1;
          state_nxt    = S_CPF_RD;
        end
      end
      S_CPF_RD: begin
        cmd.rd_file = 1'b1;
        state_nxt   = S_CPF_WR;
      end
      S_CPF_WR: begin
        cmd.cp_wr       = 1'b1;
        cmd.cp_src_file = 1'b1;
        if (sts.file_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_COMMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CPF_RD;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_R_NEW;
      end
      S_R_NONE: begin
        if (sts.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_R_FOUND: begin
        if (sts.out_free) begin
          cmd.resp       = 1'b1;
          cmd.resp_found = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_R_NEW: begin
        if (sts.out_free) begin
          cmd.resp       = 1'b1;
          cmd.resp_found = 1'b1;
          cmd.resp_new   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
    if (cfg_we) state_nxt = S_CLR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_resp_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp |-> sts.out_free) else $error("result loaded over a waiting word");
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.table_full) else $error("insert into a full table");
  a_hash_file: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hash_file |-> !sts.file_empty) else $error("file hash with empty file");
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_table |=> !in_tready) else $error("input taken during clear pass");

endmodule
`default_nettype wire

/* hdl/skit_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module skit_dp #(
  parameter int FRAMES      = 256,
  parameter int BUCKETS     = 512,
  parameter int KEY_MAX     = 256,
  parameter int ARENA_BYTES = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire skit_pkg::cmd_t           cmd,
  output skit_pkg::sts_t                sts,
  input  wire logic [skit_pkg::IN_DW-1:0] in_tdata,
  input  wire logic                     cfg_we,
  input  wire logic [skit_pkg::CAP_W-1:0] cfg_data,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [skit_pkg::OUT_DW-1:0]   out_tdata,
  output logic                          out_tuser
);
  import skit_pkg::*;

  localparam int FID_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int BV_W   = $clog2(FRAMES + 1);
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int LEN_W  = $clog2(KEY_MAX + 1);
  localparam int KW     = $clog2(KEY_MAX);
  localparam int AR_W   = $clog2(ARENA_BYTES);
  localparam int FILL_W = $clog2(ARENA_BYTES + 1);
  localparam int CMPW   = ((LEN_W > FILL_W) ? LEN_W : FILL_W) + 1;

  typedef struct packed {
    logic [31:0]      hash;
    logic [31:0]      line;
    logic [LEN_W-1:0] nlen;
    logic [LEN_W-1:0] flen;
    logic [AR_W-1:0]  noff;
    logic [AR_W-1:0]  foff;
  } ent_t;

  function automatic logic [CNT_W-1:0] eff_of(input logic [CAP_W-1:0] c);
    logic [31:0] v;
    v = {{(32-CAP_W){1'b0}}, c};
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(FRAMES)) v = 32'(FRAMES);
    return v[CNT_W-1:0];
  endfunction

  function automatic logic [BKT_W-1:0] mask_of(input logic [CNT_W-1:0] e);
    logic [31:0] need;
    logic [31:0] nb;
    need = 32'(e) << 1;
    nb   = 32'd1 << BKT_W;
    for (int k = BKT_W; k >= MIN_BKT_LOG; k--) begin
      if ((32'd1 << k) >= need) nb = 32'd1 << k;
    end
    nb = nb - 32'd1;
    return nb[BKT_W-1:0];
  endfunction

  logic [7:0]       name_mem [KEY_MAX];
  logic [7:0]       file_mem [KEY_MAX];
  logic [BV_W-1:0]  bkt_mem  [BUCKETS];
  ent_t             ent_mem  [FRAMES];
  logic [7:0]       arena_mem[ARENA_BYTES];

  logic [31:0]      hash_r;
  logic [31:0]      line_r;
  logic [LEN_W-1:0] name_cnt_r;
  logic [LEN_W-1:0] file_cnt_r;
  logic [LEN_W-1:0] idx_r;
  logic [BKT_W-1:0] slot_r;
  logic [BKT_W-1:0] pcnt_r;
  logic [BKT_W-1:0] clr_addr_r;
  logic [BKT_W-1:0] mask_r;
  logic [CNT_W-1:0] cap_eff_r;
  logic [CNT_W-1:0] ent_cnt_r;
  logic [HITS_W-1:0] hits_r;
  logic [FILL_W-1:0] fill_r;
  logic [AR_W-1:0]  noff_r;
  logic [AR_W-1:0]  foff_r;
  logic [7:0]       name_rd_r;
  logic [7:0]       file_rd_r;
  logic [7:0]       arena_rd_r;
  logic [BV_W-1:0]  bkt_rd_r;
  ent_t             ent_rd_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [ID_W-1:0]  out_id_r;
  logic [HITS_W-1:0] out_hits_r;

  logic [7:0]       in_byte;
  logic [31:0]      in_line;
  logic [31:0]      mul_in;
  logic [31:0]      mul_out;
  logic [7:0]       line_byte;
  logic [CMPW-1:0]  room;
  logic [CMPW-1:0]  ar_sum;
  logic [AR_W-1:0]  ar_base;
  logic [BV_W-1:0]  cand_v;
  logic [CNT_W-1:0] new_v;
  logic [FID_W-1:0] res_id;
  logic [FID_W+ID_W-1:0] res_ext;
  logic [CNT_W:0]   cnt_inc;
  logic             key_clear;

  assign in_byte   = in_tdata[7:0];
  assign in_line   = in_tdata[39:8];
  assign line_byte = 8'(line_r >> {idx_r[1:0], 3'b000});

  always_comb begin
    unique case (1'b1)
      cmd.hash_file: mul_in = hash_r ^ {24'b0, file_rd_r};
      cmd.hash_line: mul_in = hash_r ^ {24'b0, line_byte};
      default:       mul_in = hash_r ^ {24'b0, in_byte};
    endcase
  end
  assign mul_out = mul_in * FNV_PRIME;

  assign room    = CMPW'(ARENA_BYTES) - CMPW'(fill_r);
  assign ar_base = cmd.rd_cmp_file ? ent_rd_r.foff : ent_rd_r.noff;
  assign ar_sum  = CMPW'(ar_base) + CMPW'(idx_r);
  assign cand_v  = bkt_rd_r - BV_W'(1);
  assign new_v   = ent_cnt_r - CNT_W'(1);
  assign res_id  = cmd.resp_new ? new_v[FID_W-1:0] : cand_v[FID_W-1:0];
  assign res_ext = {{ID_W{1'b0}}, res_id};
  assign cnt_inc = {1'b0, ent_cnt_r} + (CNT_W+1)'(1);
  assign key_clear = cmd.resp || cmd.clr_table || cfg_we;

  always_comb begin
    sts             = '0;
    sts.name_empty  = (name_cnt_r == '0);
    sts.file_empty  = (file_cnt_r == '0);
    sts.name_last   = (idx_r == name_cnt_r - LEN_W'(1));
    sts.file_last   = (idx_r == file_cnt_r - LEN_W'(1));
    sts.line_last   = (idx_r[1:0] == 2'd3);
    sts.bkt_empty   = (bkt_rd_r == '0);
    sts.hdr_eq      = (ent_rd_r.hash == hash_r) && (ent_rd_r.line == line_r) &&
                      (ent_rd_r.nlen == name_cnt_r) && (ent_rd_r.flen == file_cnt_r);
    sts.name_eq     = (name_rd_r == arena_rd_r);
    sts.file_eq     = (file_rd_r == arena_rd_r);
    sts.probe_last  = (pcnt_r == mask_r);
    sts.table_full  = (ent_cnt_r >= cap_eff_r);
    sts.name_no_fit = (CMPW'(name_cnt_r) > room);
    sts.file_no_fit = (CMPW'(file_cnt_r) > room);
    sts.clr_last    = (clr_addr_r == BKT_W'(BUCKETS - 1));
    sts.out_free    = !out_valid_r || out_tready;
  end

  // key buffers and hash
  always_ff @(posedge clk) begin
    if (cmd.key_name && (name_cnt_r < LEN_W'(KEY_MAX))) begin
      name_mem[name_cnt_r[KW-1:0]] <= in_byte;
    end
    if (cmd.rd_name || cmd.rd_cmp_name) begin
      name_rd_r <= name_mem[idx_r[KW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_file && (file_cnt_r < LEN_W'(KEY_MAX))) begin
      file_mem[file_cnt_r[KW-1:0]] <= in_byte;
    end
    if (cmd.rd_file || cmd.rd_cmp_file) begin
      file_rd_r <= file_mem[idx_r[KW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      bkt_mem[clr_addr_r] <= '0;
    end else if (cmd.commit) begin
      bkt_mem[slot_r] <= cnt_inc[BV_W-1:0];
    end
    if (cmd.rd_bkt) begin
      bkt_rd_r <= bkt_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ent_mem[ent_cnt_r[FID_W-1:0]] <= '{hash: hash_r, line: line_r, nlen: name_cnt_r,
                                        flen: file_cnt_r, noff: noff_r, foff: foff_r};
    end
    if (cmd.rd_ent) begin
      ent_rd_r <= ent_mem[cand_v[FID_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_wr) begin
      arena_mem[fill_r[AR_W-1:0]] <= cmd.cp_src_file ? file_rd_r : name_rd_r;
    end
    if (cmd.rd_cmp_name || cmd.rd_cmp_file) begin
      arena_rd_r <= arena_mem[ar_sum[AR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_latch) line_r <= in_line;
    if (cmd.set_noff) noff_r <= fill_r[AR_W-1:0];
    if (cmd.set_foff) foff_r <= fill_r[AR_W-1:0];
    if (cmd.probe_start) begin
      slot_r <= hash_r[BKT_W-1:0] & mask_r;
      pcnt_r <= '0;
    end else if (cmd.probe_next) begin
      slot_r <= (slot_r + BKT_W'(1)) & mask_r;
      pcnt_r <= pcnt_r + BKT_W'(1);
    end
    if (cmd.idx_clr || cmd.fin_latch) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= FNV_BASIS;
      name_cnt_r  <= '0;
      file_cnt_r  <= '0;
      ent_cnt_r   <= '0;
      hits_r      <= '0;
      fill_r      <= '0;
      clr_addr_r  <= '0;
      cap_eff_r   <= eff_of(CAP_W'(256));
      mask_r      <= mask_of(eff_of(CAP_W'(256)));
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_eff_r <= eff_of(cfg_data);
        mask_r    <= mask_of(eff_of(cfg_data));
      end
      if (key_clear) begin
        hash_r     <= FNV_BASIS;
        name_cnt_r <= '0;
        file_cnt_r <= '0;
      end else begin
        if (cmd.key_name && (name_cnt_r < LEN_W'(KEY_MAX))) begin
          name_cnt_r <= name_cnt_r + LEN_W'(1);
          hash_r     <= mul_out;
        end
        if (cmd.key_file && (file_cnt_r < LEN_W'(KEY_MAX))) begin
          file_cnt_r <= file_cnt_r + LEN_W'(1);
        end
        if (cmd.hash_file || cmd.hash_line) hash_r <= mul_out;
      end
      if (cmd.clr_table || cfg_we) begin
        ent_cnt_r  <= '0;
        hits_r     <= '0;
        fill_r     <= '0;
        clr_addr_r <= '0;
      end else begin
        if (cmd.clr_step) clr_addr_r <= clr_addr_r + BKT_W'(1);
        if (cmd.commit) ent_cnt_r <= cnt_inc[CNT_W-1:0];
        if (cmd.cp_wr) fill_r <= fill_r + FILL_W'(1);
        if (cmd.hit && (hits_r != '1)) hits_r <= hits_r + HITS_W'(1);
      end
      if (cmd.resp) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_found_r <= cmd.resp_found;
      out_id_r    <= cmd.resp_found ? res_ext[ID_W-1:0] : '0;
      out_hits_r  <= hits_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {out_hits_r, out_id_r};

endmodule
`default_nettype wire
